// ===== rtl/core/urs_pkg.sv =====
// ----------------------------------------------------------------------------
// urs_pkg
// Shared widths, register indexes and job types for the 12-bit uniform
// rejection sampler.
// ----------------------------------------------------------------------------
package urs_pkg;

  localparam int BYTE_W     = 8;
  localparam int COEFF_W    = 12;
  localparam int BOUND_W    = 13;
  localparam int CNT_W      = 9;
  localparam int IDX_W      = 8;
  localparam int MAX_COEFFS = 256;

  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;

  localparam logic [BOUND_W-1:0] BOUND_RESET = 13'd3329;
  localparam logic [CNT_W-1:0]   COUNT_RESET = 9'd256;

  localparam logic REG_ACCEPT_BOUND = 1'b0;
  localparam logic REG_COEFF_COUNT  = 1'b1;

  typedef struct packed {
    logic [COEFF_W-1:0] value;
    logic [IDX_W-1:0]   index;
    logic               done;
  } slot_t;

  // One third byte's worth of kept coefficients: slot0 always present,
  // slot1 present when two is set.
  typedef struct packed {
    slot_t slot0;
    slot_t slot1;
    logic  two;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/core/urs_front.sv =====
// ----------------------------------------------------------------------------
// urs_front
// Accepts stream bytes, tracks the triple phase and the kept count, and
// classifies each completed triple into a job for the back end.
// ----------------------------------------------------------------------------
module urs_front import urs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [BOUND_W-1:0]  cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [BYTE_W-1:0]   in_data_byte,
  input  logic                in_start_poly,
  input  q_stat_t             q_stat,
  output logic                push,
  output job_t                push_job
);

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  logic [BOUND_W-1:0] bound_r;
  logic [CNT_W-1:0]   coeff_count_r;
  logic [1:0]         phase_r, phase_nxt;
  logic [BYTE_W-1:0]  held1_r, held1_nxt;
  logic [BYTE_W-1:0]  held2_r, held2_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  logic               take;
  logic [CNT_W-1:0]   target;
  logic [CNT_W-1:0]   cnt_eff;
  logic [CNT_W-1:0]   cnt1;
  logic [1:0]         phase_eff;
  logic [COEFF_W-1:0] c0, c1;
  logic               k0, k1;
  logic               done_a, done_b;

  assign in_stall = q_stat.full;
  assign take     = in_valid && !in_stall;

  always_comb begin
    target    = (coeff_count_r > CNT_W'(MAX_COEFFS)) ? CNT_W'(MAX_COEFFS) : coeff_count_r;
    cnt_eff   = in_start_poly ? '0 : count_r;
    phase_eff = in_start_poly ? PH_FIRST : phase_r;
    c0        = {held2_r[3:0], held1_r};
    c1        = {in_data_byte, held2_r[7:4]};
    k0        = {1'b0, c0} < bound_r;
    cnt1      = cnt_eff + CNT_W'(k0);
    k1        = (cnt1 < target) && ({1'b0, c1} < bound_r);
    done_a    = ({1'b0, cnt_eff} + (CNT_W+1)'(1)) >= {1'b0, target};
    done_b    = ({1'b0, cnt1} + (CNT_W+1)'(1)) >= {1'b0, target};

    phase_nxt = phase_r;
    held1_nxt = held1_r;
    held2_nxt = held2_r;
    count_nxt = count_r;
    push      = 1'b0;

    push_job.slot1.value = c1;
    push_job.slot1.index = cnt1[IDX_W-1:0];
    push_job.slot1.done  = done_b;
    push_job.two         = k0 && k1;
    if (k0) begin
      push_job.slot0.value = c0;
      push_job.slot0.index = cnt_eff[IDX_W-1:0];
      push_job.slot0.done  = done_a;
    end else begin
      push_job.slot0.value = c1;
      push_job.slot0.index = cnt_eff[IDX_W-1:0];
      push_job.slot0.done  = done_a;
    end

    if (take) begin
      count_nxt = cnt_eff;
      phase_nxt = phase_eff;
      if (cnt_eff < target) begin
        case (phase_eff)
          PH_FIRST: begin
            held1_nxt = in_data_byte;
            phase_nxt = PH_SECOND;
          end
          PH_SECOND: begin
            held2_nxt = in_data_byte;
            phase_nxt = PH_THIRD;
          end
          default: begin
            phase_nxt = PH_FIRST;
            count_nxt = cnt1 + CNT_W'(k1);
            push      = k0 || k1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_r       <= BOUND_RESET;
      coeff_count_r <= COUNT_RESET;
      phase_r       <= PH_FIRST;
      held1_r       <= '0;
      held2_r       <= '0;
      count_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ACCEPT_BOUND: bound_r       <= cfg_wdata;
          REG_COEFF_COUNT:  coeff_count_r <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      phase_r <= phase_nxt;
      held1_r <= held1_nxt;
      held2_r <= held2_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/urs_queue.sv =====
// ----------------------------------------------------------------------------
// urs_queue
// Short job queue between the classifying front end and the emitting back
// end.
// ----------------------------------------------------------------------------
module urs_queue import urs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head,
  output q_stat_t q_stat
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] fill_r;

  assign q_stat.full  = (fill_r == QCNT_W'(QDEPTH));
  assign q_stat.empty = (fill_r == '0);
  assign head         = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      fill_r <= fill_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

// ===== rtl/core/urs_back.sv =====
// ----------------------------------------------------------------------------
// urs_back
// Drains jobs from the queue and issues one coefficient per cycle through
// the output register while out_stall is low.
// ----------------------------------------------------------------------------
module urs_back import urs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  job_t               head,
  input  q_stat_t            q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COEFF_W-1:0] out_coeff_value,
  output logic [IDX_W-1:0]   out_coeff_index,
  output logic               out_poly_done,
  output logic               out_run_last
);

  logic  valid_r;
  logic  sel_r, sel_nxt;
  slot_t slot_r;
  logic  last_r;
  logic  can_load;
  logic  last_slot;
  slot_t cur;

  assign can_load  = !valid_r || !out_stall;
  assign last_slot = sel_r || !head.two;
  assign cur       = sel_r ? head.slot1 : head.slot0;
  assign pop       = can_load && !q_stat.empty && last_slot;

  always_comb begin
    sel_nxt = sel_r;
    if (can_load && !q_stat.empty) begin
      sel_nxt = !last_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load) begin
      slot_r <= cur;
      last_r <= last_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      if (can_load) valid_r <= !q_stat.empty;
      sel_r <= sel_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_coeff_value = slot_r.value;
  assign out_coeff_index = slot_r.index;
  assign out_poly_done   = slot_r.done;
  assign out_run_last    = last_r;

endmodule

// ===== rtl/core/uniform_rejection_sampler_12bit.sv =====
// ----------------------------------------------------------------------------
// uniform_rejection_sampler_12bit
// Rejection sampler for 12-bit coefficients from a pseudorandom byte stream.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle while in_stall is low. Every third byte of a
// triple yields up to two coefficients, which are queued as one job in a
// four-deep queue and leave through the output register at one coefficient
// per cycle while out_stall is low, so the input sustains one byte per cycle
// while the result side keeps pace; a result passes through the queue memory
// and then the output register. in_stall is raised only while that queue is
// full, i.e. when the result side has been stalled long enough to back it up.
module uniform_rejection_sampler_12bit import urs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [BOUND_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BYTE_W-1:0]  in_data_byte,
  input  logic               in_start_poly,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COEFF_W-1:0] out_coeff_value,
  output logic [IDX_W-1:0]   out_coeff_index,
  output logic               out_poly_done,
  output logic               out_run_last
);

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  job_t    push_job;
  job_t    head;

  urs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_start_poly (in_start_poly),
    .q_stat        (q_stat),
    .push          (push),
    .push_job      (push_job)
  );

  urs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  urs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_stat          (q_stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_coeff_value (out_coeff_value),
    .out_coeff_index (out_coeff_index),
    .out_poly_done   (out_poly_done),
    .out_run_last    (out_run_last)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("job pushed into full queue");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_run_last) |=> (out_valid && out_run_last))
    else $error("second coefficient of a pair missing");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_poly_done) |-> out_run_last)
    else $error("coefficient issued after polynomial done");

endmodule
